// File: sv/integer_arith_unit_with_pow_macros.svh
// assertion macros for the integer arithmetic unit
// used by the port checker; no other dependencies
`ifndef INTEGER_ARITH_UNIT_WITH_POW_MACROS_SVH
`define INTEGER_ARITH_UNIT_WITH_POW_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define IAU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define IAU_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/iau_pkg.sv
// shared types and constants for the integer arithmetic unit
// no dependencies
package iau_pkg;

    // default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // operation codes
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_ADD = 3'd0;
    localparam t_kind KIND_SUB = 3'd1;
    localparam t_kind KIND_MUL = 3'd2;
    localparam t_kind KIND_DIV = 3'd3;
    localparam t_kind KIND_MOD = 3'd4;
    localparam t_kind KIND_POW = 3'd5;

endpackage

// File: sv/iau_mul.sv
// shared multiplier: low half of the product, registered output
// no dependencies
module iau_mul #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    output logic [W-1:0] o_product
);

    logic [W-1:0] r_product;
    logic [W-1:0] n_product;

    // wrapping product, low bits only
    assign n_product = i_x * i_y;

    always_ff @(posedge i_clk) begin
        r_product <= n_product;
    end

    assign o_product = r_product;

endmodule

// File: sv/iau_div.sv
// bit-serial restoring divider on unsigned magnitudes, one quotient bit a cycle
// no dependencies
module iau_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_dvs, n_dvs;

    logic [W:0]    w_shift;
    logic [W:0]    w_diff;
    logic          w_ge;

    // one trial subtraction per cycle
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    // step control
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[W-2:0], w_ge};
            n_rem = w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: sv/integer_arith_unit_with_pow.sv
// add and subtract: result in the cycle after the input word is taken; multiply: through S_MUL and S_MULR
// divide and modulo: S_DIV until the bit-serial divider signals done
// power: S_POW_A checks the exponent, S_POW_B multiplies in a set exponent bit, S_POW_C squares
// one word in flight; the input stalls from acceptance through the cycle the result is taken
// synchronous active-low reset returns to idle and clears the error flag
module integer_arith_unit_with_pow #(
    parameter int DATA_WIDTH = iau_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  iau_pkg::t_kind               i_kind,
    input  logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [DATA_WIDTH-1:0] i_operand_b,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic                         o_error_flag
);

    import iau_pkg::*;

    localparam int W = DATA_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_MULR  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_POW_A = 3'd4;
    localparam logic [2:0] S_POW_B = 3'd5;
    localparam logic [2:0] S_POW_C = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [W-1:0] ONE  = {{(W-1){1'b0}}, 1'b1};
    localparam logic [W-1:0] ALL1 = '1;

    logic [2:0]   r_state, n_state;
    t_kind        r_kind, n_kind;
    logic [W-1:0] r_a, n_a;       // multiplicand or dividend, or running square for power
    logic [W-1:0] r_b, n_b;       // multiplier or divisor, or remaining exponent
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_value, n_value;
    logic         r_err, n_err;

    logic [W-1:0] w_a, w_b;
    logic [W-1:0] w_mag_a, w_mag_b, w_mag_rb;
    logic         w_in_acc, w_out_acc;
    logic [W-1:0] w_mul_x, w_mul_y, w_prod;
    logic         w_div_start, w_div_done;
    logic [W-1:0] w_quo, w_rem;

    // handshake
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = (r_state == S_OUT);

    // operand magnitudes
    assign w_a      = i_operand_a;
    assign w_b      = i_operand_b;
    assign w_mag_a  = w_a[W-1] ? ('0 - w_a) : w_a;
    assign w_mag_b  = w_b[W-1] ? ('0 - w_b) : w_b;
    assign w_mag_rb = r_b[W-1] ? ('0 - r_b) : r_b;

    // multiplier operand select
    always_comb begin
        w_mul_x = r_a;
        w_mul_y = r_a;
        case (r_state)
            S_MUL: begin
                w_mul_x = r_a;
                w_mul_y = r_b;
            end
            S_POW_A: begin
                w_mul_x = r_b[0] ? r_acc : r_a;
                w_mul_y = r_a;
            end
            default: begin
                w_mul_x = r_a;
                w_mul_y = r_a;
            end
        endcase
    end

    iau_mul #(.W(W)) u_mul (
        .i_clk     (i_clk),
        .i_x       (w_mul_x),
        .i_y       (w_mul_y),
        .o_product (w_prod)
    );

    assign w_div_start = (r_state == S_IDLE) && w_in_acc && (w_b != '0)
                         && ((i_kind == KIND_DIV) || (i_kind == KIND_MOD));

    iau_div #(.W(W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_mag_a),
        .i_divisor   (w_mag_b),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_value = r_value;
        n_err   = r_err;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_kind = i_kind;
                    n_a    = w_a;
                    n_b    = w_b;
                    n_acc  = ONE;
                    case (i_kind)
                        KIND_ADD: begin
                            n_value = w_a + w_b;
                            n_state = S_OUT;
                        end
                        KIND_SUB: begin
                            n_value = w_a - w_b;
                            n_state = S_OUT;
                        end
                        KIND_MUL: begin
                            n_state = S_MUL;
                        end
                        KIND_DIV, KIND_MOD: begin
                            if (w_b == '0) begin
                                n_value = ALL1;
                                n_err   = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        KIND_POW: begin
                            if (w_b[W-1]) begin
                                // negative power
                                n_state = S_OUT;
                                if (w_a == '0) begin
                                    n_value = ALL1;
                                    n_err   = 1'b1;
                                end else begin
                                    n_err = 1'b0;
                                    if (w_a == ONE) begin
                                        n_value = ONE;
                                    end else if (w_a == ALL1) begin
                                        n_value = w_b[0] ? ALL1 : ONE;
                                    end else begin
                                        n_value = '0;
                                    end
                                end
                            end else begin
                                n_state = S_POW_A;
                            end
                        end
                        default: begin
                            n_value = '0;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_state = S_MULR;
            end
            S_MULR: begin
                n_value = w_prod;
                n_state = S_OUT;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_err   = 1'b0;
                    n_state = S_OUT;
                    if (r_kind == KIND_DIV) begin
                        n_value = (r_a[W-1] ^ r_b[W-1]) ? ('0 - w_quo) : w_quo;
                    end else begin
                        n_value = (r_a[W-1] && (w_rem != '0)) ? (w_mag_rb - w_rem) : w_rem;
                    end
                end
            end
            S_POW_A: begin
                // exponent exhausted, or multiply in a set bit, or go straight to squaring for a clear bit
                if (r_b == '0) begin
                    n_value = r_acc;
                    n_err   = 1'b0;
                    n_state = S_OUT;
                end else if (r_b[0]) begin
                    n_state = S_POW_B;
                end else begin
                    n_state = S_POW_C;
                end
            end
            S_POW_B: begin
                n_acc   = w_prod;
                n_state = S_POW_C;
            end
            S_POW_C: begin
                n_a     = w_prod;
                n_b     = {1'b0, r_b[W-1:1]};
                n_state = S_POW_A;
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_error_flag = r_err;

endmodule

// File: sv/iau_checker.sv
// port-level checks for the integer arithmetic unit, bound to the top level
// depends on integer_arith_unit_with_pow_macros.svh
`include "integer_arith_unit_with_pow_macros.svh"

module iau_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_error_flag
);

    // no new word is taken while a result word is pending
    `IAU_ASSERT_IMP(a_stall_while_result, i_clk, i_rst_n, o_valid, o_stall, "input taken while result pending")

    // unit goes busy right after it takes a word
    `IAU_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "not busy after accept")

    // result word stays until taken
    `IAU_ASSERT_NXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")

    // error flag only moves when a new result word appears
    `IAU_ASSERT_IMP(a_flag_with_result, i_clk, i_rst_n, $past(i_rst_n) && !$rose(o_valid), $stable(o_error_flag), "error flag changed without a result")

endmodule

bind integer_arith_unit_with_pow iau_checker u_iau_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_error_flag (o_error_flag)
);
